// ----- rtl/rech_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rech_pkg
// Shared types and codes of the row extent convex hull block.
// ----------------------------------------------------------------------------
package rech_pkg;

   // fixed port widths
   localparam int COORD_W     = 12;
   localparam int ROW_INDEX_W = 10;

   // item kinds
   localparam logic KIND_APPEND = 1'b0;
   localparam logic KIND_QUERY  = 1'b1;

   // chain select
   localparam logic SIDE_LEFT  = 1'b0;
   localparam logic SIDE_RIGHT = 1'b1;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load_req;
      logic clear_region;
      logic set_ovf;
      logic inc_rows;
      logic side;
      logic t_load_top;
      logic t_dec;
      logic rd_pop;
      logic mul_pop;
      logic push;
      logic push_zero;
      logic srch_init;
      logic rd_mid;
      logic srch_upd;
      logic rd_eval;
      logic mul_eval;
      logic div_start;
      logic take_vertex;
      logic take_quot;
      logic out_load;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic is_query;
      logic first;
      logic rows_zero;
      logic full;
      logic row_in;
      logic t_zero;
      logic keep;
      logic lo_eq_hi;
      logic eval_vertex;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

// ----- rtl/rech_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rech_div
// Restoring divider, one quotient bit per cycle, quotient known to fit QB bits.
// ----------------------------------------------------------------------------
module rech_div
   import rech_pkg::*;
#(
   parameter int DVW = 25,
   parameter int DSW = 11,
   parameter int QB  = 13
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [DVW-1:0] dividend,
   input  logic [DSW-1:0] divisor,
   output logic [QB-1:0]  quotient,
   output logic           done
);

   localparam int CNTW = $clog2(QB);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [DVW-1:0]  rem_ff, rem_in;
   logic [DVW-1:0]  dsh_ff, dsh_in;
   logic [QB-1:0]   q_ff, q_in;
   logic            ge;

   assign ge = (rem_ff >= dsh_ff);

   // one compare and subtract per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNTW'(QB - 1);
         rem_in  = dividend;
         dsh_in  = DVW'(divisor) << (QB - 1);
      end else if (busy_ff) begin
         if (ge) begin
            rem_in = rem_ff - dsh_ff;
         end
         q_in   = {q_ff[QB-2:0], ge};
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
   end

   assign quotient = q_ff;
   assign done     = done_ff;

endmodule

// ----- rtl/rech_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rech_dp
// Datapath: chain memory, stack pointers, slope test, interpolation, result.
// ----------------------------------------------------------------------------
module rech_dp
   import rech_pkg::*;
#(
   parameter int MAX_ROWS = 1024,
   parameter int X_BITS   = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output status_type             st,
   input  logic                   req_kind,
   input  logic                   req_first_row,
   input  logic [COORD_W-1:0]     req_row_left,
   input  logic [COORD_W-1:0]     req_row_right,
   input  logic [ROW_INDEX_W-1:0] req_row_index,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [COORD_W-1:0]     rsp_hull_left,
   output logic [COORD_W-1:0]     rsp_hull_right,
   output logic                   rsp_row_valid,
   output logic                   rsp_overflow
);

   localparam int YW  = $clog2(MAX_ROWS);
   localparam int RLW = $clog2(MAX_ROWS + 1);
   localparam int EW  = X_BITS + YW;
   localparam int PW  = X_BITS + YW + 2;
   localparam int NW  = X_BITS + YW + 3;
   localparam int DVW = NW - 1;
   localparam int QB  = X_BITS + 1;

   // latched item
   logic                   kind_ff, first_ff;
   logic [X_BITS-1:0]      xl_ff, xr_ff;
   logic [ROW_INDEX_W-1:0] r_ff;

   // region state
   logic [RLW-1:0] rows_ff;
   logic           ovf_ff;
   logic [YW-1:0]  top_ff [2];
   logic [YW-1:0]  top_sel;

   // working indexes
   logic [YW-1:0] t_ff, lo_ff, hi_ff, mid_ff, mid;
   logic [YW-1:0] addr_a, addr_b, wp;
   logic          rd_en;

   // chain memory and read data
   logic [EW-1:0] mem [2][MAX_ROWS];
   logic [EW-1:0] da_ff, db_ff;
   logic [X_BITS-1:0] xa, xb, xn;
   logic [YW-1:0]     ya, yb, yn;

   // arithmetic
   logic signed [X_BITS:0] dx_pop_n, dx_pop_t, dx_ev;
   logic [YW-1:0]          dy_t, dy_n, dy_ev, k;
   logic signed [PW-1:0]   pl_ff, pr_ff, pb_ff;
   logic [EW-1:0]          pa_ff;
   logic signed [NW-1:0]   num;
   logic                   neg_ff;
   logic [QB-1:0]          quot;
   logic                   div_done;

   // results
   logic [X_BITS-1:0] hl_ff, hr_ff;
   logic              row_in;
   logic              rsp_valid_ff, row_valid_ff, ovf_out_ff;
   logic [COORD_W-1:0] hl_out_ff, hr_out_ff;

   assign top_sel = top_ff[cmd.side];
   assign xa = da_ff[EW-1:YW];
   assign ya = da_ff[YW-1:0];
   assign xb = db_ff[EW-1:YW];
   assign yb = db_ff[YW-1:0];
   assign xn = (cmd.side == SIDE_RIGHT) ? xr_ff : xl_ff;
   assign yn = YW'(rows_ff);
   assign mid = YW'(({1'b0, lo_ff} + {1'b0, hi_ff} + 1'b1) >> 1);
   assign wp  = cmd.push_zero ? '0 : YW'(t_ff + 1'b1);
   assign row_in = ({{(32-ROW_INDEX_W){1'b0}}, r_ff} < {{(32-RLW){1'b0}}, rows_ff});

   // latched item and region counters
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         kind_ff  <= req_kind;
         first_ff <= req_first_row;
         xl_ff    <= X_BITS'(req_row_left);
         xr_ff    <= X_BITS'(req_row_right);
         r_ff     <= req_row_index;
      end
      if (reset) begin
         rows_ff   <= '0;
         ovf_ff    <= 1'b0;
         top_ff[0] <= '0;
         top_ff[1] <= '0;
      end else begin
         if (cmd.clear_region) begin
            rows_ff <= '0;
            ovf_ff  <= 1'b0;
         end
         if (cmd.set_ovf) begin
            ovf_ff <= 1'b1;
         end
         if (cmd.inc_rows) begin
            rows_ff <= rows_ff + 1'b1;
         end
         if (cmd.push) begin
            top_ff[cmd.side] <= wp;
         end
      end
   end

   // stack pointer and search bounds
   always_ff @(posedge clock) begin
      if (cmd.t_load_top) begin
         t_ff <= top_sel;
      end else if (cmd.t_dec) begin
         t_ff <= t_ff - 1'b1;
      end
      if (cmd.rd_mid) begin
         mid_ff <= mid;
      end
      if (cmd.srch_init) begin
         lo_ff <= '0;
         hi_ff <= top_sel;
      end else if (cmd.srch_upd) begin
         if (ya <= YW'(r_ff)) begin
            lo_ff <= mid_ff;
         end else begin
            hi_ff <= mid_ff - 1'b1;
         end
      end
   end

   // read address select
   always_comb begin
      addr_a = lo_ff;
      addr_b = lo_ff;
      if (cmd.rd_pop) begin
         addr_a = t_ff;
         addr_b = t_ff - 1'b1;
      end else if (cmd.rd_mid) begin
         addr_a = mid;
      end else if (cmd.rd_eval) begin
         addr_b = lo_ff + 1'b1;
      end
   end
   assign rd_en = cmd.rd_pop | cmd.rd_mid | cmd.rd_eval;

   // chain memory, one write and two registered reads
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[cmd.side][wp] <= {xn, yn};
      end
      if (rd_en) begin
         da_ff <= mem[cmd.side][addr_a];
         db_ff <= mem[cmd.side][addr_b];
      end
   end

   // slope cross products for the pop test
   assign dx_pop_n = $signed({1'b0, xn}) - $signed({1'b0, xa});
   assign dx_pop_t = $signed({1'b0, xa}) - $signed({1'b0, xb});
   assign dy_t     = ya - yb;
   assign dy_n     = yn - ya;

   // interpolation terms
   assign dx_ev = $signed({1'b0, xb}) - $signed({1'b0, xa});
   assign dy_ev = yb - ya;
   assign k     = YW'(r_ff) - ya;

   always_ff @(posedge clock) begin
      if (cmd.mul_pop) begin
         pl_ff <= dx_pop_n * $signed({1'b0, dy_t});
         pr_ff <= dx_pop_t * $signed({1'b0, dy_n});
      end
      if (cmd.mul_eval) begin
         pa_ff <= EW'(xa) * EW'(dy_ev);
         pb_ff <= $signed({1'b0, k}) * dx_ev;
      end
      if (cmd.div_start) begin
         neg_ff <= num[NW-1];
      end
   end

   // 2*x0*dy + dy + 2*k*dx
   assign num = $signed({{(NW-EW-1){1'b0}}, pa_ff, 1'b0})
              + $signed({{(NW-YW){1'b0}}, dy_ev})
              + $signed({pb_ff, 1'b0});

   rech_div #(
      .DVW (DVW),
      .DSW (YW + 1),
      .QB  (QB)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (num[NW-2:0]),
      .divisor  ({dy_ev, 1'b0}),
      .quotient (quot),
      .done     (div_done)
   );

   // per side hull x
   always_ff @(posedge clock) begin
      if (cmd.take_vertex) begin
         if (cmd.side == SIDE_RIGHT) begin
            hr_ff <= xa;
         end else begin
            hl_ff <= xa;
         end
      end else if (cmd.take_quot) begin
         if (cmd.side == SIDE_RIGHT) begin
            hr_ff <= neg_ff ? '0 : quot[X_BITS-1:0];
         end else begin
            hl_ff <= neg_ff ? '0 : quot[X_BITS-1:0];
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         row_valid_ff <= row_in;
         ovf_out_ff   <= ovf_ff;
         hl_out_ff    <= row_in ? COORD_W'(hl_ff) : '0;
         hr_out_ff    <= row_in ? COORD_W'(hr_ff) : '0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hull_left  = hl_out_ff;
   assign rsp_hull_right = hr_out_ff;
   assign rsp_row_valid  = row_valid_ff;
   assign rsp_overflow   = ovf_out_ff;

   // status
   always_comb begin
      st.is_query    = (kind_ff == KIND_QUERY);
      st.first       = first_ff;
      st.rows_zero   = (rows_ff == '0);
      st.full        = (rows_ff == RLW'(MAX_ROWS));
      st.row_in      = row_in;
      st.t_zero      = (t_ff == '0);
      st.keep        = (cmd.side == SIDE_RIGHT) ? (pl_ff < pr_ff) : (pl_ff > pr_ff);
      st.lo_eq_hi    = (lo_ff == hi_ff);
      st.eval_vertex = (ya == YW'(r_ff)) || (lo_ff == top_sel);
      st.div_done    = div_done;
      st.out_free    = !rsp_valid_ff || !rsp_stall;
   end

endmodule

// ----- rtl/rech_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rech_ctrl
// Controller: sequences appends, pops, searches and interpolation per chain.
// ----------------------------------------------------------------------------
module rech_ctrl
   import rech_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type st,
   output cmd_type    cmd
);

   typedef enum logic [4:0] {
      S_IDLE,
      S_DECIDE,
      S_CHECK,
      S_ADD_INIT,
      S_POP_RD,
      S_POP_MUL,
      S_POP_CMP,
      S_PUSH,
      S_SRCH_INIT,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_EV_RD,
      S_EV_CHK,
      S_EV_MUL,
      S_EV_SUM,
      S_EV_DIV,
      S_RESULT
   } state_type;

   state_type state_ff, state_in;
   logic      side_ff, side_in;
   logic      start_ff, start_in;

   assign req_stall = (state_ff != S_IDLE);

   // next state and command decode
   always_comb begin
      state_in = state_ff;
      side_in  = side_ff;
      start_in = start_ff;
      cmd      = '0;
      cmd.side = side_ff;
      cmd.push_zero = start_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (!st.is_query && st.first) begin
               cmd.clear_region = 1'b1;
            end
            state_in = S_CHECK;
         end
         S_CHECK: begin
            side_in = SIDE_LEFT;
            if (st.is_query) begin
               state_in = st.row_in ? S_SRCH_INIT : S_RESULT;
            end else if (st.rows_zero) begin
               start_in = 1'b1;
               state_in = S_PUSH;
            end else if (st.full) begin
               cmd.set_ovf = 1'b1;
               state_in = S_IDLE;
            end else begin
               start_in = 1'b0;
               state_in = S_ADD_INIT;
            end
         end
         S_ADD_INIT: begin
            cmd.t_load_top = 1'b1;
            state_in = S_POP_RD;
         end
         S_POP_RD: begin
            if (st.t_zero) begin
               state_in = S_PUSH;
            end else begin
               cmd.rd_pop = 1'b1;
               state_in = S_POP_MUL;
            end
         end
         S_POP_MUL: begin
            cmd.mul_pop = 1'b1;
            state_in = S_POP_CMP;
         end
         S_POP_CMP: begin
            if (st.keep) begin
               state_in = S_PUSH;
            end else begin
               cmd.t_dec = 1'b1;
               state_in = S_POP_RD;
            end
         end
         S_PUSH: begin
            cmd.push = 1'b1;
            if (side_ff == SIDE_LEFT) begin
               side_in  = SIDE_RIGHT;
               state_in = start_ff ? S_PUSH : S_ADD_INIT;
            end else begin
               cmd.inc_rows = 1'b1;
               start_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         S_SRCH_INIT: begin
            cmd.srch_init = 1'b1;
            state_in = S_SRCH_RD;
         end
         S_SRCH_RD: begin
            if (st.lo_eq_hi) begin
               state_in = S_EV_RD;
            end else begin
               cmd.rd_mid = 1'b1;
               state_in = S_SRCH_CMP;
            end
         end
         S_SRCH_CMP: begin
            cmd.srch_upd = 1'b1;
            state_in = S_SRCH_RD;
         end
         S_EV_RD: begin
            cmd.rd_eval = 1'b1;
            state_in = S_EV_CHK;
         end
         S_EV_CHK: begin
            if (st.eval_vertex) begin
               cmd.take_vertex = 1'b1;
               side_in  = SIDE_RIGHT;
               state_in = (side_ff == SIDE_LEFT) ? S_SRCH_INIT : S_RESULT;
            end else begin
               state_in = S_EV_MUL;
            end
         end
         S_EV_MUL: begin
            cmd.mul_eval = 1'b1;
            state_in = S_EV_SUM;
         end
         S_EV_SUM: begin
            cmd.div_start = 1'b1;
            state_in = S_EV_DIV;
         end
         S_EV_DIV: begin
            if (st.div_done) begin
               cmd.take_quot = 1'b1;
               side_in  = SIDE_RIGHT;
               state_in = (side_ff == SIDE_LEFT) ? S_SRCH_INIT : S_RESULT;
            end
         end
         S_RESULT: begin
            if (st.out_free) begin
               cmd.out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         side_ff  <= SIDE_LEFT;
         start_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         side_ff  <= side_in;
         start_ff <= start_in;
      end
   end

endmodule

// ----- rtl/row_extent_convex_hull.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// row_extent_convex_hull
// Convex hull of a region given row by row as left and right extents.
// ----------------------------------------------------------------------------
// One item at a time. An append either starts a region or is dropped past
// capacity. Any other append works on each of the two chains in turn through
// one memory, popping vertices, at most down to the chain's bottom vertex.
// A query on a row outside the region goes straight to the result; otherwise,
// for each chain, it runs a binary search that halves the chain's depth per
// step and, where the row lies between vertices, the bit serial divider.
// A query also waits while the previous result is still held in the output
// register. The chain memory needs no clearing after reset. A finished result
// waits in an output register while the next item is accepted.
// ----------------------------------------------------------------------------
module row_extent_convex_hull
   import rech_pkg::*;
#(
   parameter int MAX_ROWS = 1024,
   parameter int X_BITS   = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_kind,
   input  logic                   req_first_row,
   input  logic [COORD_W-1:0]     req_row_left,
   input  logic [COORD_W-1:0]     req_row_right,
   input  logic [ROW_INDEX_W-1:0] req_row_index,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [COORD_W-1:0]     rsp_hull_left,
   output logic [COORD_W-1:0]     rsp_hull_right,
   output logic                   rsp_row_valid,
   output logic                   rsp_overflow
);

   cmd_type    cmd;
   status_type st;

   // controller
   rech_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .st        (st),
      .cmd       (cmd)
   );

   // datapath
   rech_dp #(
      .MAX_ROWS (MAX_ROWS),
      .X_BITS   (X_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .st             (st),
      .req_kind       (req_kind),
      .req_first_row  (req_first_row),
      .req_row_left   (req_row_left),
      .req_row_right  (req_row_right),
      .req_row_index  (req_row_index),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hull_left  (rsp_hull_left),
      .rsp_hull_right (rsp_hull_right),
      .rsp_row_valid  (rsp_row_valid),
      .rsp_overflow   (rsp_overflow)
   );

   // an accepted item blocks the next one while it is worked on
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("item accepted while previous one still in work");

   // a result is never loaded over one still waiting
   a_out_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> st.out_free)
      else $error("result overwrote a pending result");

   // memory write never shares a cycle with a chain read
   a_mem_no_clash: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> !(cmd.rd_pop || cmd.rd_mid || cmd.rd_eval))
      else $error("chain write and read in the same cycle");

   // divider cannot report done right after a start
   a_div_latency: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> !st.div_done)
      else $error("divider finished too early");

endmodule
